// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the entity decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define HE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a rising clock edge outside reset.
`define HE_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: hw/rtl/htmlent_pkg.sv
// Shared constants and types of the HTML entity decoder.
package htmlent_pkg;

  // Entity window depth, ampersand included
  localparam int EntWin = 12;
  localparam int CntW   = $clog2(EntWin + 1);
  localparam int PosW   = $clog2(EntWin);

  // Numeric references must stay below this value
  localparam int NumLimit = 128;
  localparam int ValW     = $clog2(NumLimit);
  localparam int AccW     = ValW + 4;

  // Characters of interest
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChQuot  = 8'h22;
  localparam logic [7:0] ChApos  = 8'h27;

  // Source of an emitted byte
  typedef enum logic [1:0] {
    EMIT_HEAD  = 2'd0,
    EMIT_AMP   = 2'd1,
    EMIT_NAMED = 2'd2,
    EMIT_NUM   = 2'd3
  } emit_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      shift;
    logic      dec_start;
    logic      dec_step;
    logic      drop_load;
    logic      drop_step;
    logic      emit;
    emit_sel_e emit_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic head_amp;
    logic semi_found;
    logic named_hit;
    logic numeric_form;
    logic dec_done;
    logic num_ok;
    logic drop_last;
    logic full;
    logic eot_held;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/html_entity_decoder.sv
// Top level of the HTML character entity decoder.
// Input stream: one text byte per transfer on s_axis, tlast on the final byte
// of a text run. Output stream: decoded bytes on m_axis, tlast on the final
// decoded byte of the run. A '&' opens a window of up to 12 bytes; a ';'
// inside it closes an entity (named lt/gt/amp/quot/apos, decimal or hex
// numeric) which is replaced by one character. A failed window releases its
// '&' raw and the following bytes are scanned again; at end of run any open
// window is flushed raw.
// Flow: an input transfer is taken only when the scan of the previous byte
// has finished. A plain byte is accepted, emitted, then ends the scan. A
// numeric entity adds a decode set-up step, a step per digit position after
// '#' or '#x' and a step per consumed window byte; a failed window rescans
// its bytes. All of this runs on the single scan sequencer over the window
// buffer.
// Output has a one-entry register: the scan continues while a result waits
// and pauses only when another byte must be emitted while m_axis is stalled.
// Reset empties the window and clears the output valid flag; no clearing pass.
module html_entity_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // end_of_text
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] decoded_byte
  output logic       m_axis_tlast    // last_byte
);

  htmlent_pkg::cmd_t cmd;
  htmlent_pkg::sts_t sts;

  htmlent_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  htmlent_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

endmodule

// File: hw/rtl/htmlent_dp.sv
// Datapath of the entity decoder: window buffer, numeric accumulator, output register.
`include "assert_macros.svh"

module htmlent_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  htmlent_pkg::cmd_t   cmd_i,
  output htmlent_pkg::sts_t   sts_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  input  logic                out_ready_i
);

  logic [7:0]                      buf_q [htmlent_pkg::EntWin];
  logic [htmlent_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                            eot_q;
  logic [htmlent_pkg::PosW-1:0]    k_q, end_q;
  logic [htmlent_pkg::ValW-1:0]    val_q;
  logic                            big_q, hex_q;
  logic [htmlent_pkg::CntW-1:0]    drop_q;
  logic                            out_valid_q;
  logic [7:0]                      out_byte_q;
  logic                            out_last_q;

  logic                            semi_found;
  logic [htmlent_pkg::PosW-1:0]    semi_pos;
  logic                            named_hit;
  logic [7:0]                      named_char;
  logic [7:0]                      dig_byte;
  logic [3:0]                      dig_val;
  logic                            dig_use;
  logic [htmlent_pkg::AccW-1:0]    acc;
  logic                            out_free;
  logic [7:0]                      emit_byte;
  logic                            emit_last;
  logic [htmlent_pkg::CntW-1:0]    cnt_m1;

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] r;
    r = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) r = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) r = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) r = 4'(c - 8'h37);
    return r;
  endfunction

  // First semicolon after the head within the filled part of the window
  always_comb begin
    semi_found = 1'b0;
    semi_pos   = '0;
    for (int p = 1; p < htmlent_pkg::EntWin; p++) begin
      if (!semi_found && htmlent_pkg::CntW'(p) < cnt_q && buf_q[p] == htmlent_pkg::ChSemi) begin
        semi_found = 1'b1;
        semi_pos   = htmlent_pkg::PosW'(p);
      end
    end
  end

  // Named forms, matched on fixed window positions
  always_comb begin
    named_hit  = 1'b1;
    named_char = htmlent_pkg::ChAmp;
    if (semi_pos == htmlent_pkg::PosW'(3) && buf_q[1] == 8'h6C && buf_q[2] == 8'h74)
      named_char = htmlent_pkg::ChLt;
    else if (semi_pos == htmlent_pkg::PosW'(3) && buf_q[1] == 8'h67 && buf_q[2] == 8'h74)
      named_char = htmlent_pkg::ChGt;
    else if (semi_pos == htmlent_pkg::PosW'(4) && buf_q[1] == 8'h61 && buf_q[2] == 8'h6D
             && buf_q[3] == 8'h70)
      named_char = htmlent_pkg::ChAmp;
    else if (semi_pos == htmlent_pkg::PosW'(5) && buf_q[1] == 8'h71 && buf_q[2] == 8'h75
             && buf_q[3] == 8'h6F && buf_q[4] == 8'h74)
      named_char = htmlent_pkg::ChQuot;
    else if (semi_pos == htmlent_pkg::PosW'(5) && buf_q[1] == 8'h61 && buf_q[2] == 8'h70
             && buf_q[3] == 8'h6F && buf_q[4] == 8'h73)
      named_char = htmlent_pkg::ChApos;
    else
      named_hit = 1'b0;
  end

  // One digit per cycle into the accumulator
  always_comb begin
    dig_byte = buf_q[k_q];
    if (hex_q) begin
      dig_val = hex_val(dig_byte);
      dig_use = 1'b1;
    end else begin
      dig_val = 4'(dig_byte - 8'h30);
      dig_use = (dig_byte >= 8'h30 && dig_byte <= 8'h39);
    end
    if (hex_q) acc = {htmlent_pkg::AccW'(val_q)} << 4;
    else       acc = htmlent_pkg::AccW'(val_q) * htmlent_pkg::AccW'(10);
    acc = acc + htmlent_pkg::AccW'(dig_val);
  end

  // Output byte selection and last-byte mark
  assign cnt_m1 = cnt_q - htmlent_pkg::CntW'(1);
  always_comb begin
    case (cmd_i.emit_sel)
      htmlent_pkg::EMIT_HEAD: begin
        emit_byte = buf_q[0];
        emit_last = eot_q && cnt_q == htmlent_pkg::CntW'(1);
      end
      htmlent_pkg::EMIT_AMP: begin
        emit_byte = htmlent_pkg::ChAmp;
        emit_last = eot_q && cnt_q == htmlent_pkg::CntW'(1);
      end
      htmlent_pkg::EMIT_NAMED: begin
        emit_byte = named_char;
        emit_last = eot_q && htmlent_pkg::CntW'(semi_pos) == cnt_m1;
      end
      default: begin
        emit_byte = {{(8 - htmlent_pkg::ValW){1'b0}}, val_q};
        emit_last = eot_q && htmlent_pkg::CntW'(end_q) == cnt_m1;
      end
    endcase
  end

  // Fill count
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load)       cnt_d = cnt_q + htmlent_pkg::CntW'(1);
    else if (cmd_i.shift) cnt_d = cnt_m1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      eot_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.load) eot_q <= in_last_i;
      if (cmd_i.emit)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Window buffer: append at the fill point, consume from the head
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < htmlent_pkg::EntWin - 1; i++) begin
      if (cmd_i.load && cnt_q == htmlent_pkg::CntW'(i)) buf_q[i] <= in_byte_i;
      else if (cmd_i.shift) buf_q[i] <= buf_q[i + 1];
    end
    if (cmd_i.load && cnt_q == htmlent_pkg::CntW'(htmlent_pkg::EntWin - 1))
      buf_q[htmlent_pkg::EntWin - 1] <= in_byte_i;
  end

  // Numeric decode and drop counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.dec_start) begin
      end_q <= semi_pos;
      hex_q <= (buf_q[2] == 8'h78 || buf_q[2] == 8'h58);
      k_q   <= (buf_q[2] == 8'h78 || buf_q[2] == 8'h58) ? htmlent_pkg::PosW'(3)
                                                       : htmlent_pkg::PosW'(2);
      val_q <= '0;
      big_q <= 1'b0;
    end else if (cmd_i.dec_step) begin
      k_q <= k_q + htmlent_pkg::PosW'(1);
      if (!big_q && dig_use) begin
        val_q <= acc[htmlent_pkg::ValW-1:0];
        big_q <= acc >= htmlent_pkg::AccW'(htmlent_pkg::NumLimit);
      end
    end
    if (cmd_i.drop_load) begin
      drop_q <= (cmd_i.emit_sel == htmlent_pkg::EMIT_NAMED)
                  ? htmlent_pkg::CntW'(semi_pos) + htmlent_pkg::CntW'(1)
                  : htmlent_pkg::CntW'(end_q) + htmlent_pkg::CntW'(1);
    end else if (cmd_i.drop_step) begin
      drop_q <= drop_q - htmlent_pkg::CntW'(1);
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // Status back to the controller
  always_comb begin
    sts_o.cnt_zero     = cnt_q == '0;
    sts_o.head_amp     = buf_q[0] == htmlent_pkg::ChAmp;
    sts_o.semi_found   = semi_found;
    sts_o.named_hit    = named_hit;
    sts_o.numeric_form = semi_pos >= htmlent_pkg::PosW'(2) && buf_q[1] == htmlent_pkg::ChHash;
    sts_o.dec_done     = k_q == end_q;
    sts_o.num_ok       = !big_q && val_q != '0;
    sts_o.drop_last    = drop_q == htmlent_pkg::CntW'(1);
    sts_o.full         = cnt_q == htmlent_pkg::CntW'(htmlent_pkg::EntWin);
    sts_o.eot_held     = eot_q;
    sts_o.out_free     = out_free;
  end

  `HE_NEVER(a_fill_range, clk_i, rst_ni, cnt_q > htmlent_pkg::CntW'(htmlent_pkg::EntWin))
  `HE_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_i.emit && out_valid_q && !out_ready_i)

endmodule

// File: hw/rtl/htmlent_ctrl.sv
// Controller state machine of the entity decoder.
`include "assert_macros.svh"

module htmlent_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  htmlent_pkg::sts_t sts_i,
  output htmlent_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECODE = 4'b0100,
    ST_DROP   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.cnt_zero) begin
          state_d = ST_IDLE;
        end else if (!sts_i.head_amp) begin
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = htmlent_pkg::EMIT_HEAD;
            cmd_o.shift    = 1'b1;
          end
        end else if (sts_i.semi_found) begin
          if (sts_i.named_hit) begin
            if (sts_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_sel  = htmlent_pkg::EMIT_NAMED;
              cmd_o.drop_load = 1'b1;
              state_d         = ST_DROP;
            end
          end else if (sts_i.numeric_form) begin
            cmd_o.dec_start = 1'b1;
            state_d         = ST_DECODE;
          end else if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = htmlent_pkg::EMIT_AMP;
            cmd_o.shift    = 1'b1;
          end
        end else if (sts_i.full || sts_i.eot_held) begin
          // window cannot close: ampersand goes out raw
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = htmlent_pkg::EMIT_AMP;
            cmd_o.shift    = 1'b1;
          end
        end else begin
          // open window stays for the next byte
          state_d = ST_IDLE;
        end
      end
      ST_DECODE: begin
        if (!sts_i.dec_done) begin
          cmd_o.dec_step = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.num_ok) begin
            cmd_o.emit_sel  = htmlent_pkg::EMIT_NUM;
            cmd_o.drop_load = 1'b1;
            state_d         = ST_DROP;
          end else begin
            cmd_o.emit_sel = htmlent_pkg::EMIT_AMP;
            cmd_o.shift    = 1'b1;
            state_d        = ST_SCAN;
          end
        end
      end
      ST_DROP: begin
        cmd_o.shift     = 1'b1;
        cmd_o.drop_step = 1'b1;
        if (sts_i.drop_last) state_d = ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  `HE_ASSERT(a_window_head, clk_i, rst_ni,
             (state_q == ST_IDLE && !sts_i.cnt_zero) |-> sts_i.head_amp)
  `HE_ASSERT(a_eot_flushed, clk_i, rst_ni,
             (state_q == ST_IDLE && sts_i.eot_held) |-> sts_i.cnt_zero)

endmodule

// File: tb/sv/html_entity_decoder_checker.sv
// Stream checker for the HTML entity decoder: predicts decoded bytes and compares them.
module html_entity_decoder_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // end_of_text
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] decoded_byte
  input  logic       m_axis_tlast,   // last_byte
  output int         error_count_o,
  output int         pending_o,
  output int         checked_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_t;

  // Expected decoded bytes, oldest first
  decoded_t   decoded_q [$];

  // Own copy of the open entity window
  logic [7:0] window_mem [htmlent_pkg::EntWin];
  int         window_fill = 0;

  // Held window plus the new byte, scanned per transfer
  logic [7:0] scan_buf [htmlent_pkg::EntWin + 1];
  logic [7:0] step_bytes [$];

  int errors  = 0;
  int checked = 0;

  assign error_count_o = errors;
  assign checked_o     = checked;

  initial pending_o = 0;

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return 0;
  endfunction

  // Decode scan_buf[s..e] ('&' .. ';'); zero means the entity failed
  function automatic logic [7:0] decode_entity(input int s, input int e);
    int          len;
    int          k;
    int          v;
    bit          big;
    logic [47:0] head;
    len  = e - s + 1;
    head = '0;
    for (k = 0; k < 6; k++) begin
      head = {head[39:0], (s + k <= htmlent_pkg::EntWin) ? scan_buf[s + k] : 8'h00};
    end
    if (len == 4 && head[47:16] == "&lt;") return htmlent_pkg::ChLt;
    if (len == 4 && head[47:16] == "&gt;") return htmlent_pkg::ChGt;
    if (len == 5 && head[47:8] == "&amp;") return htmlent_pkg::ChAmp;
    if (len == 6 && head == "&quot;") return htmlent_pkg::ChQuot;
    if (len == 6 && head == "&apos;") return htmlent_pkg::ChApos;
    if (len < 3 || scan_buf[s + 1] != htmlent_pkg::ChHash) return 8'h00;
    v   = 0;
    big = 1'b0;
    if (scan_buf[s + 2] == "x" || scan_buf[s + 2] == "X") begin
      // hex: stray characters count as digit zero
      for (k = 3; k + 1 < len; k++) begin
        if (!big) begin
          v = v * 16 + hex_value(scan_buf[s + k]);
          if (v >= htmlent_pkg::NumLimit) big = 1'b1;
        end
      end
    end else begin
      // decimal: non-digits are skipped
      for (k = 2; k + 1 < len; k++) begin
        if (!big && scan_buf[s + k] >= "0" && scan_buf[s + k] <= "9") begin
          v = v * 10 + (int'(scan_buf[s + k]) - 48);
          if (v >= htmlent_pkg::NumLimit) big = 1'b1;
        end
      end
    end
    if (big || v == 0) return 8'h00;
    return v[7:0];
  endfunction

  // Work out the decoded bytes caused by one input transfer
  task automatic predict_transfer(input logic [7:0] text_byte, input logic eot);
    int         n;
    int         i;
    int         j;
    int         k;
    int         lim;
    bit         found;
    bit         kept;
    bit         stop;
    logic [7:0] ch;
    decoded_t   entry;
    n = window_fill;
    if (n > htmlent_pkg::EntWin - 1) n = htmlent_pkg::EntWin - 1;
    for (i = 0; i < n; i++) scan_buf[i] = window_mem[i];
    scan_buf[n] = text_byte;
    n++;
    step_bytes.delete();
    i    = 0;
    kept = 1'b0;
    stop = 1'b0;
    while (i < n && !stop) begin
      if (scan_buf[i] != htmlent_pkg::ChAmp) begin
        step_bytes.push_back(scan_buf[i]);
        i++;
      end else begin
        lim = i + htmlent_pkg::EntWin - 1;
        if (lim > n - 1) lim = n - 1;
        found = 1'b0;
        j     = i + 1;
        while (j <= lim && !found) begin
          if (scan_buf[j] == htmlent_pkg::ChSemi) found = 1'b1;
          else j++;
        end
        if (found) begin
          ch = decode_entity(i, j);
          if (ch != 8'h00) begin
            step_bytes.push_back(ch);
            i = j + 1;
          end else begin
            // failed entity: raw ampersand, rescan the rest
            step_bytes.push_back(htmlent_pkg::ChAmp);
            i++;
          end
        end else if (n - i >= htmlent_pkg::EntWin || eot) begin
          // window overrun or end of text
          step_bytes.push_back(htmlent_pkg::ChAmp);
          i++;
        end else begin
          for (k = 0; k < n - i; k++) window_mem[k] = scan_buf[i + k];
          window_fill = n - i;
          kept        = 1'b1;
          stop        = 1'b1;
        end
      end
    end
    if (!kept || eot) window_fill = 0;
    for (k = 0; k < step_bytes.size(); k++) begin
      entry.data = step_bytes[k];
      entry.last = eot && (k == step_bytes.size() - 1);
      decoded_q.push_back(entry);
    end
  endtask

  // Predict on input transfers, compare on output transfers
  always @(posedge clk_i) begin
    decoded_t head;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_transfer(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        checked++;
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer: expected none, actual byte %02h last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          head = decoded_q.pop_front();
          if (m_axis_tdata !== head.data) begin
            errors++;
            $display("%0t: decoded_byte mismatch: expected %02h, actual %02h",
                     $time, head.data, m_axis_tdata);
          end
          if (m_axis_tlast !== head.last) begin
            errors++;
            $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                     $time, head.last, m_axis_tlast);
          end
        end
      end
    end
    pending_o <= decoded_q.size();
  end

endmodule

// File: tb/sv/html_entity_decoder_tb.sv
// Top of the HTML entity decoder testbench: clock, reset, text stimulus and verdict.
module html_entity_decoder_tb;

  localparam int RandomItems = 185;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 200;
  localparam int CycleLimit  = 1000000;
  localparam int HoldAfter   = 80;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  int error_count;
  int pending_count;
  int checked_count;

  int cycle_count  = 0;
  int bytes_sent   = 0;
  int random_sent  = 0;
  int runs_ended   = 0;
  bit burst_mode   = 1'b0;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;

  // Bytes of the text fragment being sent
  logic [7:0] token_q [$];

  string hex_chars = "0123456789abcdefABCDEF";

  html_entity_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  html_entity_decoder_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .error_count_o (error_count),
    .pending_o     (pending_count),
    .checked_o     (checked_count)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly short idle gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One input transfer, then an optional idle gap
  task automatic send_byte(input logic [7:0] text_byte, input logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= text_byte;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    if (last) runs_ended++;
    gap = burst_mode ? 0 : idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_str(input string s, input bit last);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], last && (i == s.len() - 1));
  endtask

  task automatic push_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) token_q.push_back(s[i]);
  endtask

  // Build one text fragment: mostly well-formed entities, some noise and broken ones
  task automatic build_token();
    int         kind;
    int         cnt;
    int         i;
    logic [7:0] c;
    token_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      // plain bytes of any value
      cnt = $urandom_range(1, 4);
      for (i = 0; i < cnt; i++) begin
        c = 8'($urandom_range(0, 255));
        token_q.push_back(c);
      end
    end else if (kind < 45) begin
      case ($urandom_range(0, 4))
        0: push_str("&lt;");
        1: push_str("&gt;");
        2: push_str("&amp;");
        3: push_str("&quot;");
        default: push_str("&apos;");
      endcase
      // now and then spoil the name
      if ($urandom_range(0, 5) == 0) begin
        c = 8'(8'h61 + $urandom_range(0, 25));
        token_q[$urandom_range(1, token_q.size() - 2)] = c;
      end
    end else if (kind < 60) begin
      // decimal, sometimes with stray letters or a long run of digits
      push_str("&#");
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 11) : $urandom_range(0, 3);
      for (i = 0; i < cnt; i++) begin
        if ($urandom_range(0, 7) == 0) c = 8'(8'h61 + $urandom_range(0, 25));
        else if ($urandom_range(0, 3) == 0) c = "0";
        else c = 8'(8'h30 + $urandom_range(0, 9));
        token_q.push_back(c);
      end
      token_q.push_back(";");
    end else if (kind < 75) begin
      // hex, either case of x, sometimes non-hex characters
      push_str($urandom_range(0, 1) ? "&#x" : "&#X");
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 2);
      for (i = 0; i < cnt; i++) begin
        if ($urandom_range(0, 7) == 0) c = 8'(8'h67 + $urandom_range(0, 19));
        else if ($urandom_range(0, 3) == 0) c = "0";
        else c = hex_chars[$urandom_range(0, 21)];
        token_q.push_back(c);
      end
      token_q.push_back(";");
    end else if (kind < 85) begin
      // semicolon around the edge of the window
      token_q.push_back("&");
      cnt = $urandom_range(9, 13);
      for (i = 0; i < cnt; i++) begin
        c = 8'(8'h61 + $urandom_range(0, 25));
        token_q.push_back(c);
      end
      token_q.push_back(";");
    end else if (kind < 95) begin
      // open window with no semicolon, may hold more ampersands
      token_q.push_back("&");
      cnt = $urandom_range(0, 6);
      for (i = 0; i < cnt; i++) begin
        c = ($urandom_range(0, 3) == 0) ? 8'h26 : 8'(8'h61 + $urandom_range(0, 25));
        token_q.push_back(c);
      end
    end else begin
      // stray ampersand in front of an entity
      push_str("&&lt;");
    end
  endtask

  // Send a fragment, sometimes ending the text run on it or cutting it short
  task automatic send_token();
    int sel;
    int i;
    bit last;
    sel  = $urandom_range(0, 15);
    last = 1'b0;
    if (sel == 0 && token_q.size() > 1) begin
      i = $urandom_range(1, token_q.size());
      while (token_q.size() > i) void'(token_q.pop_back());
      last = 1'b1;
    end else if (sel < 3) begin
      last = 1'b1;
    end
    for (i = 0; i < token_q.size(); i++) begin
      send_byte(token_q[i], last && (i == token_q.size() - 1));
      random_sent++;
    end
  endtask

  // Receiver: random stalls, free-running stretches and one long hold-off
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 19) == 0) repeat ($urandom_range(50, 150)) @(posedge clk_i);
        else repeat ($urandom_range(1, 8)) @(posedge clk_i);
        gap = idle_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: named and numeric forms, empty and oversized numbers,
    // field extremes, end-of-text flush and a lone trailing ampersand
    send_str("&lt;", 1'b0);
    send_str("&#65;", 1'b0);
    send_str("&#x;", 1'b0);
    send_str("&#999;", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_str("&zz", 1'b1);
    send_str("&", 1'b1);

    // random fragments
    while (random_sent < RandomItems) begin
      if (random_sent >= HoldAfter && !hold_req) hold_req = 1'b1;
      if ($urandom_range(0, 9) == 0) burst_mode = !burst_mode;
      build_token();
      send_token();
    end
    send_byte(".", 1'b1);
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d text bytes in %0d ended runs, checked %0d decoded bytes",
             bytes_sent, runs_ended, checked_count);
    $display("Output held off once for %0d cycles to back up the input", HoldCycles);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
